>>> rtl/core/robot_mode_sequencer_defines.svh
// ----------------------------------------------------------------------------
// Robot mode sequencer assertion macros
// Shared property forms for the port-level checker of the mode sequencer.
// ----------------------------------------------------------------------------
`ifndef ROBOT_MODE_SEQUENCER_DEFINES_SVH
`define ROBOT_MODE_SEQUENCER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RMS_ASSERT_IMP(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RMS_ASSERT_NXT(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/rms_pkg.sv
// ----------------------------------------------------------------------------
// Robot mode sequencer package
// Mode and preset codes, register indexes, reset values and word layouts.
// ----------------------------------------------------------------------------
package rms_pkg;

	typedef enum logic [3:0] {
		MODE_NONE          = 4'd0,
		MODE_RUN           = 4'd1,
		MODE_SHRINK        = 4'd2,
		MODE_RECOVER       = 4'd3,
		MODE_BALANCE       = 4'd4,
		MODE_FOLLOW_GIMBAL = 4'd5,
		MODE_FOLLOW_SIDE   = 4'd6,
		MODE_SELF_ROTATE   = 4'd7,
		MODE_SLIDE         = 4'd8,
		MODE_FLY           = 4'd9,
		MODE_LAND          = 4'd10,
		MODE_JUMP_PRE      = 4'd11,
		MODE_JUMP_UP       = 4'd12,
		MODE_JUMP_DOWN     = 4'd13
	} mode_t;

	typedef enum logic [2:0] {
		PID_NONE      = 3'd0,
		PID_JUMP_PREP = 3'd1,
		PID_FLY       = 3'd2,
		PID_LAND      = 3'd3,
		PID_JUMP_UP   = 3'd4,
		PID_JUMP_DOWN = 3'd5,
		PID_RAW_LEG   = 3'd6
	} pid_t;

	typedef enum logic [1:0] {
		CFG_ENERGY_THRESHOLD = 2'd0,
		CFG_HOLD_TICKS       = 2'd1,
		CFG_JUMP_PREP_TICKS  = 2'd2
	} cfg_idx_t;

	localparam logic [11:0] ENERGY_THRESHOLD_RST = 12'd880;
	localparam logic [31:0] HOLD_TICKS_RST       = 32'd1000000;
	localparam logic [31:0] JUMP_PREP_TICKS_RST  = 32'd200000;

	localparam int unsigned IN_ITEM_W  = 54;
	localparam int unsigned IN_TDATA_W = 56;
	localparam int unsigned OUT_ITEM_W  = 10;
	localparam int unsigned OUT_TDATA_W = 16;

	// Packed structs list the first field last so that it lands in the low bits.
	typedef struct packed {
		logic [31:0] now_time;
		logic        power_fault;
		logic        abnormal;
		logic        ground_force;
		logic [11:0] stored_energy;
		logic        shrink_done;
		logic        motor_fault;
		logic        sensor_off;
		logic [3:0]  requested_mode;
	} in_item_t;

	typedef struct packed {
		logic        settle_delay;
		logic        battery_limit_set;
		pid_t        pid_preset;
		logic        online;
		mode_t       mode;
	} out_item_t;

endpackage

>>> rtl/core/robot_mode_sequencer.sv
// ----------------------------------------------------------------------------
// Robot mode sequencer
// Chassis operating-mode state machine, stepped once per control tick word.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid/s_axis_tready   one control tick word
// m_axis    out  m_axis_tvalid/m_axis_tready   one mode result word
// cfg       in   cfg_valid/cfg_ready           register index and data
//
// A tick word is captured in the input register and evaluated against the mode
// state in one combinational pass into the result register, which shows its
// result. One word is accepted every cycle unless the result stalls; a stalled
// result holds both registers, and the input side still accepts while the input
// register is empty. Reset clears the mode state and the valid flags and
// reloads the register defaults; configuration writes are always accepted.

module robot_mode_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// requested_mode[3:0], sensor_off[4], motor_fault[5], shrink_done[6],
	// stored_energy[18:7], ground_force[19], abnormal[20], power_fault[21],
	// now_time[53:22], zero fill [55:54]
	input  logic [55:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// mode[3:0], online[4], pid_preset[7:5], battery_limit_set[8],
	// settle_delay[9], zero fill [15:10]
	output logic [15:0] m_axis_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	// Configuration registers.
	logic [11:0] energy_threshold_q;
	logic [31:0] hold_ticks_q;
	logic [31:0] jump_prep_ticks_q;

	// Mode state carried from tick to tick.
	rms_pkg::mode_t mode_q;
	logic           online_q;
	logic [31:0]    start_time_q;

	// Input register and result register.
	rms_pkg::in_item_t  item_s1;
	logic               valid_s1;
	rms_pkg::out_item_t result_s2;
	logic               valid_s2;

	logic advance;

	// Next-state values and per-tick outputs of the transition rule.
	rms_pkg::mode_t mode_d;
	logic           online_d;
	logic [31:0]    start_time_d;
	rms_pkg::pid_t  pid_d;
	logic           bat_d;
	logic           settle_d;

	// Shared conditions.
	logic [31:0] elapsed;
	logic        hold_expired;
	logic        prep_expired;
	logic        energy_ok;
	logic        any_fault;
	logic        req_none;
	logic        balance_group;
	logic        fault_checked;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			energy_threshold_q <= rms_pkg::ENERGY_THRESHOLD_RST;
			hold_ticks_q       <= rms_pkg::HOLD_TICKS_RST;
			jump_prep_ticks_q  <= rms_pkg::JUMP_PREP_TICKS_RST;
		end else if (cfg_valid) begin
			case (rms_pkg::cfg_idx_t'(cfg_index))
				rms_pkg::CFG_ENERGY_THRESHOLD: energy_threshold_q <= cfg_data[11:0];
				rms_pkg::CFG_HOLD_TICKS:       hold_ticks_q       <= cfg_data;
				rms_pkg::CFG_JUMP_PREP_TICKS:  jump_prep_ticks_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// The word in the input register moves on whenever the result register is
	// empty or its word is being taken this cycle.
	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1 <= rms_pkg::in_item_t'(s_axis_tdata[rms_pkg::IN_ITEM_W-1:0]);
		end
	end

	// Elapsed time wraps modulo 2^32, measured from the start time held before
	// this tick.
	assign elapsed      = item_s1.now_time - start_time_q;
	assign hold_expired = elapsed > hold_ticks_q;
	assign prep_expired = elapsed > jump_prep_ticks_q;
	assign energy_ok    = item_s1.shrink_done && (item_s1.stored_energy > energy_threshold_q);
	assign any_fault    = item_s1.abnormal || item_s1.power_fault ||
	                      item_s1.sensor_off || item_s1.motor_fault;
	assign req_none     = item_s1.requested_mode == rms_pkg::MODE_NONE;

	assign balance_group = (mode_q == rms_pkg::MODE_BALANCE) ||
	                       (mode_q == rms_pkg::MODE_FOLLOW_GIMBAL) ||
	                       (mode_q == rms_pkg::MODE_FOLLOW_SIDE) ||
	                       (mode_q == rms_pkg::MODE_SELF_ROTATE);

	// Fault shutdown applies in the balance group and in the fly, land and jump modes.
	assign fault_checked = balance_group ||
	                       (mode_q inside {rms_pkg::MODE_FLY, rms_pkg::MODE_LAND,
	                                       rms_pkg::MODE_JUMP_PRE, rms_pkg::MODE_JUMP_UP,
	                                       rms_pkg::MODE_JUMP_DOWN});

	// Next state. Within one tick a later rule overrides an earlier one, so the
	// assignments below run in the same order as the rules.
	always_comb begin
		logic [3:0] req;
		logic       check_off;
		req          = item_s1.requested_mode;
		check_off    = 1'b0;
		mode_d       = mode_q;
		online_d     = online_q;
		start_time_d = start_time_q;
		case (mode_q)
			rms_pkg::MODE_NONE: begin
				if (req == rms_pkg::MODE_RUN && !item_s1.sensor_off) begin
					start_time_d = item_s1.now_time;
					online_d     = 1'b1;
					mode_d       = rms_pkg::MODE_RUN;
				end else if (!req_none && !item_s1.sensor_off) begin
					// Legs retract first unless a motor has failed.
					start_time_d = item_s1.now_time;
					online_d     = 1'b1;
					mode_d       = item_s1.motor_fault ? rms_pkg::MODE_RECOVER
					                                   : rms_pkg::MODE_SHRINK;
				end else begin
					online_d = 1'b0;
				end
			end
			rms_pkg::MODE_RUN: begin
				if (!req_none && req != rms_pkg::MODE_RUN) begin
					start_time_d = item_s1.now_time;
					online_d     = 1'b1;
					mode_d       = rms_pkg::MODE_SHRINK;
				end
				check_off = 1'b1;
			end
			rms_pkg::MODE_SHRINK: begin
				if (energy_ok) begin
					start_time_d = item_s1.now_time;
					mode_d       = rms_pkg::MODE_BALANCE;
				end
				check_off = 1'b1;
			end
			rms_pkg::MODE_RECOVER: begin
				if (!req_none && !item_s1.motor_fault) begin
					start_time_d = item_s1.now_time;
					online_d     = 1'b1;
					mode_d       = rms_pkg::MODE_SHRINK;
				end
				check_off = 1'b1;
			end
			rms_pkg::MODE_BALANCE, rms_pkg::MODE_FOLLOW_GIMBAL,
			rms_pkg::MODE_FOLLOW_SIDE, rms_pkg::MODE_SELF_ROTATE: begin
				// Most requests are copied straight into the mode.
				if (!(req inside {rms_pkg::MODE_SHRINK, rms_pkg::MODE_RECOVER,
				                  rms_pkg::MODE_SLIDE, rms_pkg::MODE_JUMP_PRE})) begin
					mode_d = rms_pkg::mode_t'(req);
				end
				if (req == rms_pkg::MODE_JUMP_PRE) begin
					// A jump request restarts the start time and takes priority over the hold below.
					start_time_d = item_s1.now_time;
					mode_d       = rms_pkg::MODE_JUMP_PRE;
				end else if (!item_s1.ground_force && hold_expired) begin
					start_time_d = item_s1.now_time;
					mode_d       = rms_pkg::MODE_FLY;
				end
			end
			rms_pkg::MODE_FLY, rms_pkg::MODE_JUMP_DOWN: begin
				if (item_s1.ground_force) begin
					start_time_d = item_s1.now_time;
					mode_d       = rms_pkg::MODE_LAND;
				end
				check_off = 1'b1;
			end
			rms_pkg::MODE_LAND: begin
				if (hold_expired) begin
					start_time_d = item_s1.now_time;
					mode_d       = rms_pkg::mode_t'(req);
				end
				check_off = 1'b1;
			end
			rms_pkg::MODE_JUMP_PRE: begin
				if (prep_expired) begin
					start_time_d = item_s1.now_time;
					mode_d       = rms_pkg::MODE_JUMP_UP;
				end
				check_off = 1'b1;
			end
			rms_pkg::MODE_JUMP_UP: begin
				if (!item_s1.ground_force) begin
					start_time_d = item_s1.now_time;
					mode_d       = rms_pkg::MODE_JUMP_DOWN;
				end
				check_off = 1'b1;
			end
			default: begin
				// Slide and undefined codes drop straight to offline.
				online_d = 1'b0;
				mode_d   = rms_pkg::MODE_NONE;
			end
		endcase
		if (check_off && req_none) begin
			online_d = 1'b0;
			mode_d   = rms_pkg::MODE_NONE;
		end
		if (fault_checked && any_fault) begin
			online_d = 1'b0;
			mode_d   = rms_pkg::MODE_NONE;
		end
	end

	// Per-tick requests: PID preset, battery limit and settle delay.
	always_comb begin
		pid_d    = rms_pkg::PID_NONE;
		bat_d    = (mode_q == rms_pkg::MODE_SHRINK) && energy_ok;
		settle_d = fault_checked && any_fault;
		case (mode_q)
			rms_pkg::MODE_BALANCE, rms_pkg::MODE_FOLLOW_GIMBAL,
			rms_pkg::MODE_FOLLOW_SIDE, rms_pkg::MODE_SELF_ROTATE: begin
				if (item_s1.requested_mode == rms_pkg::MODE_JUMP_PRE) begin
					pid_d = rms_pkg::PID_JUMP_PREP;
				end else if (!item_s1.ground_force && hold_expired) begin
					pid_d = rms_pkg::PID_FLY;
				end
			end
			rms_pkg::MODE_FLY, rms_pkg::MODE_JUMP_DOWN: begin
				if (item_s1.ground_force) begin
					pid_d = rms_pkg::PID_LAND;
				end
			end
			rms_pkg::MODE_LAND: begin
				if (hold_expired) begin
					pid_d = rms_pkg::PID_RAW_LEG;
				end
			end
			rms_pkg::MODE_JUMP_PRE: begin
				if (prep_expired) begin
					pid_d = rms_pkg::PID_JUMP_UP;
				end
			end
			rms_pkg::MODE_JUMP_UP: begin
				if (!item_s1.ground_force) begin
					pid_d = rms_pkg::PID_JUMP_DOWN;
				end
			end
			default: pid_d = rms_pkg::PID_NONE;
		endcase
	end

	// Mode state commits as the word leaves the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= rms_pkg::MODE_NONE;
			online_q     <= 1'b0;
			start_time_q <= 32'd0;
		end else if (advance) begin
			mode_q       <= mode_d;
			online_q     <= online_d;
			start_time_q <= start_time_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2.mode              <= mode_d;
			result_s2.online            <= online_d;
			result_s2.pid_preset        <= pid_d;
			result_s2.battery_limit_set <= bat_d;
			result_s2.settle_delay      <= settle_d;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {{(rms_pkg::OUT_TDATA_W - rms_pkg::OUT_ITEM_W){1'b0}}, result_s2};

endmodule

>>> rtl/core/rms_checker.sv
// ----------------------------------------------------------------------------
// Robot mode sequencer checker
// Port-level properties of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "robot_mode_sequencer_defines.svh"

module rms_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata
);

	// A stalled result word stays valid and unchanged.
	`RMS_ASSERT_NXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result word changed")

	// A settle delay comes only with a fault shutdown to offline.
	`RMS_ASSERT_IMP(a_settle_offline, clk, arst_n, m_axis_tvalid && m_axis_tdata[9], (m_axis_tdata[3:0] == rms_pkg::MODE_NONE) && !m_axis_tdata[4], "settle delay without shutdown")

	// The battery limit is requested only on leaving shrink, which lands in
	// balance unless a zero request drops the mode to none in the same tick.
	`RMS_ASSERT_IMP(a_battery_balance, clk, arst_n, m_axis_tvalid && m_axis_tdata[8], (m_axis_tdata[3:0] == rms_pkg::MODE_BALANCE) || (m_axis_tdata[3:0] == rms_pkg::MODE_NONE), "battery limit outside balance entry")

	// Any mode other than none is reported online.
	`RMS_ASSERT_IMP(a_mode_online, clk, arst_n, m_axis_tvalid && (m_axis_tdata[3:0] != rms_pkg::MODE_NONE), m_axis_tdata[4], "active mode reported offline")

endmodule

bind robot_mode_sequencer rms_checker u_rms_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// Robot mode sequencer testbench
// Drives control tick words into the sequencer and checks every mode result
// word against a cycle-free predictor of the transition rules. A directed walk
// covers the main modes, then random tick streams run under several register
// settings, with bursty input, a stalling output and one long output hold-off.
// ----------------------------------------------------------------------------

module tb_top;

	// Generous bound on the whole run.
	localparam int unsigned CYCLE_LIMIT = 200000;
	// Length of the output hold-off that fills the block and stalls its input.
	localparam int unsigned HOLD_OFF_CYCLES = 300;
	// Quiet cycles after the last result.
	localparam int unsigned DRAIN_CYCLES = 8;

	// Flag bits of the directed tick helper.
	localparam logic [5:0] F_NONE   = 6'b000000;
	localparam logic [5:0] F_SENSOR = 6'b000001;
	localparam logic [5:0] F_MOTOR  = 6'b000010;
	localparam logic [5:0] F_SHRUNK = 6'b000100;
	localparam logic [5:0] F_FORCE  = 6'b001000;
	localparam logic [5:0] F_ABN    = 6'b010000;
	localparam logic [5:0] F_PWR    = 6'b100000;

	// Result word layout, low bits last: mode, online, preset, battery, settle.
	// Plain vectors so that modes outside the package enum can be held.
	typedef struct packed {
		logic       settle;
		logic       battery;
		logic [2:0] pid;
		logic       online;
		logic [3:0] mode;
	} mode_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [55:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;

	robot_mode_sequencer uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #2 clk = ~clk;

	// Predictor copy of the registers and the mode state.
	logic [11:0] thr_energy;
	logic [31:0] hold_len;
	logic [31:0] prep_len;
	logic [3:0]  cur_mode;
	logic        is_live;
	logic [31:0] mode_t0;

	// Results predicted for accepted tick words, oldest first.
	mode_result_t expected_results[$];

	int unsigned n_errors = 0;
	int unsigned cycle_count = 0;

	// Sender pacing: bursts of words separated by random gaps, unless steady.
	int unsigned burst_left = 0;
	bit          steady_tx = 1'b0;
	// Running timer value carried into the now_time field.
	logic [31:0] timer = '0;

	// Each bump asks the receiver for one long hold-off.
	int unsigned hold_requests = 0;

	// ------------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------------

	function automatic logic [31:0] ticks_since(logic [31:0] now);
		return now - mode_t0;
	endfunction

	function automatic void restart(logic [3:0] next_mode, logic [31:0] now);
		mode_t0 = now;
		cur_mode = next_mode;
	endfunction

	// Applies one tick to the predicted state and returns the result word.
	// The elapsed time is read where each rule reads it, so a restart earlier
	// in the same tick is seen by later rules.
	function automatic mode_result_t advance_mode(rms_pkg::in_item_t t);
		mode_result_t r;
		logic [3:0] rq;
		logic fault;
		logic chk_off;
		logic chk_fault;
		r = '0;
		rq = t.requested_mode;
		fault = t.abnormal | t.power_fault | t.sensor_off | t.motor_fault;
		chk_off = 1'b0;
		chk_fault = 1'b0;
		case (cur_mode)
			rms_pkg::MODE_NONE: begin
				if (rq == rms_pkg::MODE_RUN && !t.sensor_off) begin
					restart(rms_pkg::MODE_RUN, t.now_time);
					is_live = 1'b1;
				end else if (rq != rms_pkg::MODE_NONE && !t.sensor_off) begin
					restart(t.motor_fault ? rms_pkg::MODE_RECOVER : rms_pkg::MODE_SHRINK,
							t.now_time);
					is_live = 1'b1;
				end else begin
					is_live = 1'b0;
				end
			end
			rms_pkg::MODE_RUN: begin
				if (rq != rms_pkg::MODE_NONE && rq != rms_pkg::MODE_RUN) begin
					restart(rms_pkg::MODE_SHRINK, t.now_time);
					is_live = 1'b1;
				end
				chk_off = 1'b1;
			end
			rms_pkg::MODE_SHRINK: begin
				if (t.shrink_done && t.stored_energy > thr_energy) begin
					r.battery = 1'b1;
					restart(rms_pkg::MODE_BALANCE, t.now_time);
				end
				chk_off = 1'b1;
			end
			rms_pkg::MODE_RECOVER: begin
				if (rq != rms_pkg::MODE_NONE && !t.motor_fault) begin
					restart(rms_pkg::MODE_SHRINK, t.now_time);
					is_live = 1'b1;
				end
				chk_off = 1'b1;
			end
			rms_pkg::MODE_BALANCE, rms_pkg::MODE_FOLLOW_GIMBAL,
			rms_pkg::MODE_FOLLOW_SIDE, rms_pkg::MODE_SELF_ROTATE: begin
				// The request is copied as is, odd codes included, online untouched.
				if (rq != rms_pkg::MODE_SHRINK && rq != rms_pkg::MODE_RECOVER &&
						rq != rms_pkg::MODE_SLIDE && rq != rms_pkg::MODE_JUMP_PRE)
					cur_mode = rq;
				if (rq == rms_pkg::MODE_JUMP_PRE) begin
					restart(rms_pkg::MODE_JUMP_PRE, t.now_time);
					r.pid = rms_pkg::PID_JUMP_PREP;
				end
				if (!t.ground_force && ticks_since(t.now_time) > hold_len) begin
					restart(rms_pkg::MODE_FLY, t.now_time);
					r.pid = rms_pkg::PID_FLY;
				end
				chk_fault = 1'b1;
			end
			rms_pkg::MODE_FLY: begin
				if (t.ground_force) begin
					restart(rms_pkg::MODE_LAND, t.now_time);
					r.pid = rms_pkg::PID_LAND;
				end
				chk_off = 1'b1;
				chk_fault = 1'b1;
			end
			rms_pkg::MODE_LAND: begin
				// Hold expiry takes whatever mode is requested.
				if (ticks_since(t.now_time) > hold_len) begin
					restart(rq, t.now_time);
					r.pid = rms_pkg::PID_RAW_LEG;
				end
				chk_off = 1'b1;
				chk_fault = 1'b1;
			end
			rms_pkg::MODE_JUMP_PRE: begin
				if (ticks_since(t.now_time) > prep_len) begin
					restart(rms_pkg::MODE_JUMP_UP, t.now_time);
					r.pid = rms_pkg::PID_JUMP_UP;
				end
				chk_off = 1'b1;
				chk_fault = 1'b1;
			end
			rms_pkg::MODE_JUMP_UP: begin
				if (!t.ground_force) begin
					restart(rms_pkg::MODE_JUMP_DOWN, t.now_time);
					r.pid = rms_pkg::PID_JUMP_DOWN;
				end
				chk_off = 1'b1;
				chk_fault = 1'b1;
			end
			rms_pkg::MODE_JUMP_DOWN: begin
				if (t.ground_force) begin
					restart(rms_pkg::MODE_LAND, t.now_time);
					r.pid = rms_pkg::PID_LAND;
				end
				chk_off = 1'b1;
				chk_fault = 1'b1;
			end
			default: begin
				// Slide and the unused codes drop straight to offline.
				is_live = 1'b0;
				cur_mode = rms_pkg::MODE_NONE;
			end
		endcase
		if (chk_off && rq == rms_pkg::MODE_NONE) begin
			is_live = 1'b0;
			cur_mode = rms_pkg::MODE_NONE;
		end
		if (chk_fault && fault) begin
			is_live = 1'b0;
			cur_mode = rms_pkg::MODE_NONE;
			r.settle = 1'b1;
		end
		r.mode = cur_mode;
		r.online = is_live;
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------

	// Offers one tick word and predicts its result once it is taken. Valid
	// stays high between words of a burst and drops only for a gap.
	task automatic send_tick(rms_pkg::in_item_t t);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = steady_tx ? 0 : $urandom_range(5);
			burst_left = $urandom_range(24, 1);
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {2'b00, t};
		do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
		expected_results.push_back(advance_mode(t));
	endtask

	task automatic drive_tick(logic [3:0] rq, logic [5:0] fl, logic [11:0] energy,
			logic [31:0] dt);
		rms_pkg::in_item_t t;
		timer += dt;
		t.requested_mode = rq;
		t.sensor_off = |(fl & F_SENSOR);
		t.motor_fault = |(fl & F_MOTOR);
		t.shrink_done = |(fl & F_SHRUNK);
		t.stored_energy = energy;
		t.ground_force = |(fl & F_FORCE);
		t.abnormal = |(fl & F_ABN);
		t.power_fault = |(fl & F_PWR);
		t.now_time = timer;
		send_tick(t);
	endtask

	// Mostly requests that make sense for the predicted mode, so that the
	// jump, fly and land chains are reached; the rest is any code at all.
	function automatic logic [3:0] pick_request();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 4)
			return rms_pkg::MODE_NONE;
		if (roll < 12)
			return 4'($urandom_range(15));
		case (cur_mode)
			rms_pkg::MODE_BALANCE, rms_pkg::MODE_FOLLOW_GIMBAL,
			rms_pkg::MODE_FOLLOW_SIDE, rms_pkg::MODE_SELF_ROTATE: begin
				if (roll < 80)
					return 4'($urandom_range(rms_pkg::MODE_SELF_ROTATE,
							rms_pkg::MODE_BALANCE));
				return rms_pkg::MODE_JUMP_PRE;
			end
			rms_pkg::MODE_NONE, rms_pkg::MODE_RUN, rms_pkg::MODE_SHRINK,
			rms_pkg::MODE_RECOVER: begin
				return 4'($urandom_range(rms_pkg::MODE_SELF_ROTATE, rms_pkg::MODE_RUN));
			end
			default: begin
				return 4'($urandom_range(rms_pkg::MODE_SELF_ROTATE, rms_pkg::MODE_BALANCE));
			end
		endcase
	endfunction

	// One random tick. Faults are rare so that sequences can run their course;
	// energy sits near the threshold half the time. The timer mostly creeps by
	// up to dt_max and now and then jumps anywhere, wrap included.
	task automatic send_random(int unsigned dt_max);
		rms_pkg::in_item_t t;
		t.requested_mode = pick_request();
		t.sensor_off = ($urandom_range(59) == 0);
		t.motor_fault = ($urandom_range(59) == 0);
		t.shrink_done = ($urandom_range(9) < 7);
		t.ground_force = 1'($urandom_range(1));
		t.abnormal = ($urandom_range(59) == 0);
		t.power_fault = ($urandom_range(59) == 0);
		if ($urandom_range(1) != 0)
			t.stored_energy = 12'($urandom);
		else
			t.stored_energy = thr_energy + 12'($urandom_range(4)) - 12'd2;
		if ($urandom_range(99) == 0)
			timer = $urandom();
		else
			timer += $urandom_range(dt_max);
		t.now_time = timer;
		send_tick(t);
	endtask

	// Stops offering words and waits until every predicted result has come.
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic put_reg(rms_pkg::cfg_idx_t idx, logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
	endtask

	// Writes all three registers back to back while the block is idle.
	task automatic load_settings(logic [11:0] thr, logic [31:0] hold, logic [31:0] prep);
		wait_idle();
		put_reg(rms_pkg::CFG_ENERGY_THRESHOLD, {20'd0, thr});
		put_reg(rms_pkg::CFG_HOLD_TICKS, hold);
		put_reg(rms_pkg::CFG_JUMP_PREP_TICKS, prep);
		cfg_valid <= 1'b0;
		thr_energy = thr;
		hold_len = hold;
		prep_len = prep;
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Walks the main modes with the reset register values. The timer starts just
	// below the wrap so that the jump preparation hold spans it.
	task automatic test_mode_walk();
		timer = 32'hFFFF_FF00;
		drive_tick(rms_pkg::MODE_NONE, F_NONE, 12'd0, 0);
		drive_tick(rms_pkg::MODE_RUN, F_SENSOR, 12'd0, 1);
		drive_tick(rms_pkg::MODE_RUN, F_NONE, 12'd0, 1);
		drive_tick(rms_pkg::MODE_RUN, F_ABN | F_PWR, 12'hFFF, 1);
		drive_tick(rms_pkg::MODE_FOLLOW_GIMBAL, F_NONE, 12'd0, 1);
		// Energy equal to the threshold is not enough, nor is energy alone.
		drive_tick(rms_pkg::MODE_BALANCE, F_SHRUNK, 12'd880, 1);
		drive_tick(rms_pkg::MODE_BALANCE, F_NONE, 12'hFFF, 1);
		drive_tick(rms_pkg::MODE_BALANCE, F_SHRUNK, 12'd881, 1);
		drive_tick(rms_pkg::MODE_JUMP_PRE, F_FORCE, 12'd0, 1);
		// Exactly the preparation time keeps waiting, one tick more moves on.
		drive_tick(rms_pkg::MODE_JUMP_PRE, F_FORCE, 12'd0, rms_pkg::JUMP_PREP_TICKS_RST);
		drive_tick(rms_pkg::MODE_JUMP_PRE, F_FORCE, 12'd0, 1);
		drive_tick(rms_pkg::MODE_JUMP_UP, F_FORCE, 12'd0, 1);
		drive_tick(rms_pkg::MODE_JUMP_UP, F_NONE, 12'd0, 1);
		drive_tick(rms_pkg::MODE_JUMP_DOWN, F_FORCE, 12'd0, 1);
		drive_tick(rms_pkg::MODE_SELF_ROTATE, F_FORCE, 12'd0, rms_pkg::HOLD_TICKS_RST + 1);
		// Balance copies the fly request, then the hold without ground force
		// lifts it to fly.
		drive_tick(rms_pkg::MODE_FLY, F_NONE, 12'd0, rms_pkg::HOLD_TICKS_RST + 1);
		drive_tick(rms_pkg::MODE_FLY, F_FORCE, 12'd0, 1);
		drive_tick(rms_pkg::MODE_LAND, F_SENSOR | F_FORCE, 12'd0, 1);
		drive_tick(rms_pkg::MODE_RECOVER, F_MOTOR, 12'd0, 1);
		drive_tick(rms_pkg::MODE_SHRINK, F_MOTOR, 12'd0, 1);
		drive_tick(rms_pkg::MODE_SHRINK, F_NONE, 12'd0, 1);
		// Leaving shrink and a zero request in the same tick: battery request
		// is still raised while the mode drops to none.
		drive_tick(rms_pkg::MODE_NONE, F_SHRUNK, 12'hFFF, 1);
	endtask

	// A balance-group request outside the enum is copied in, and the next tick
	// finds an unknown mode and goes offline.
	task automatic test_odd_modes();
		drive_tick(rms_pkg::MODE_SHRINK, F_NONE, 12'd0, 1);
		drive_tick(rms_pkg::MODE_SHRINK, F_SHRUNK, 12'hFFF, 1);
		drive_tick(4'd15, F_FORCE, 12'd0, 1);
		drive_tick(rms_pkg::MODE_RUN, F_NONE, 12'd0, 1);
	endtask

	// Zero holds end as soon as any time has passed.
	task automatic test_zero_holds();
		load_settings(12'd0, 32'd0, 32'd0);
		repeat (200) send_random(3);
	endtask

	// Full-scale registers: shrink is never left and no hold can expire.
	task automatic test_saturated_registers();
		load_settings(12'hFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		repeat (150) send_random(1000);
	endtask

	// Short holds so the fly, land and jump chains run often.
	task automatic test_random_settings();
		int unsigned k;
		for (k = 0; k < 5; k++) begin
			load_settings(12'($urandom), $urandom_range(40, 1), $urandom_range(40, 1));
			steady_tx = (k == 2);
			repeat (200) send_random(8);
		end
		steady_tx = 1'b0;
	endtask

	task automatic test_default_timing();
		load_settings(rms_pkg::ENERGY_THRESHOLD_RST, rms_pkg::HOLD_TICKS_RST,
				rms_pkg::JUMP_PREP_TICKS_RST);
		repeat (150) send_random(400000);
	endtask

	// The receiver holds off for a long stretch while words keep coming, so
	// both registers of the block fill and its input stalls.
	task automatic test_backpressure();
		load_settings(12'($urandom), 32'd10, 32'd10);
		steady_tx = 1'b1;
		hold_requests <= hold_requests + 1;
		repeat (100) send_random(4);
		steady_tx = 1'b0;
	endtask

	// ------------------------------------------------------------------------
	// Result checking and receiver stalls
	// ------------------------------------------------------------------------

	task automatic check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			n_errors++;
		end
	endtask

	logic [7:0]  rx_pattern = 8'hFF;
	logic [2:0]  rx_phase = '0;
	int unsigned stall_left = 0;
	int unsigned hold_seen = 0;

	always @(posedge clk) begin : rx_side
		mode_result_t got;
		mode_result_t want;
		int unsigned roll;
		if (m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata[9:0];
			if (expected_results.size() == 0) begin
				$error("result word with no tick waiting for it: %h", m_axis_tdata);
				n_errors++;
			end else begin
				want = expected_results.pop_front();
				check_field("mode", want.mode, got.mode);
				check_field("online", want.online, got.online);
				check_field("pid_preset", want.pid, got.pid);
				check_field("battery_limit_set", want.battery, got.battery);
				check_field("settle_delay", want.settle, got.settle);
			end
		end
		if (hold_seen != hold_requests) begin
			hold_seen = hold_requests;
			stall_left = HOLD_OFF_CYCLES;
		end
		if (stall_left != 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else begin
			// Ready follows an eight-bit pattern that is redrawn now and then:
			// always ready, sparse, dense, or kept as it was.
			m_axis_tready <= rx_pattern[rx_phase];
			rx_phase++;
			if (rx_phase == 0) begin
				roll = $urandom_range(3);
				case (roll)
					0: rx_pattern = 8'hFF;
					1: rx_pattern = 8'($urandom);
					2: rx_pattern = 8'($urandom) | 8'($urandom);
					default: ;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Sequence of tests
	// ------------------------------------------------------------------------

	initial begin
		thr_energy = rms_pkg::ENERGY_THRESHOLD_RST;
		hold_len = rms_pkg::HOLD_TICKS_RST;
		prep_len = rms_pkg::JUMP_PREP_TICKS_RST;
		cur_mode = rms_pkg::MODE_NONE;
		is_live = 1'b0;
		mode_t0 = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_mode_walk();
		test_odd_modes();
		test_zero_holds();
		test_saturated_registers();
		test_random_settings();
		test_default_timing();
		test_backpressure();
		wait_idle();
		if (n_errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
